FILE: rtl/core/ift_watershed_fmax_defines.svh
// Assertion macros used by the checker file of the watershed block.
// No dependencies; every macro expects i_clk and i_rst_n in scope.
`ifndef IFT_WATERSHED_FMAX_DEFINES_SVH
`define IFT_WATERSHED_FMAX_DEFINES_SVH

// Same-cycle implication.
`define WSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("watershed check failed");

// Next-cycle implication.
`define WSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("watershed check failed");

`endif

FILE: rtl/core/wsf_pkg.sv
// Package of the watershed block: payload structs, command codes, colors.
// No dependencies.
`timescale 1ns / 1ps
package wsf_pkg;

    localparam int MAX_VOXELS_DEF = 32768;
    localparam int GRAD_BITS_DEF  = 8;
    localparam int LABEL_BITS_DEF = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SEED = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GRAY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;

    localparam logic [1:0] CFG_LOG2_X = 2'd0;
    localparam logic [1:0] CFG_LOG2_Y = 2'd1;
    localparam logic [1:0] CFG_LOG2_Z = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] address;
        logic [7:0]  gradient;
        logic [8:0]  init_cost;
        logic [15:0] init_label;
    } t_cmd;

    typedef struct packed {
        logic [8:0]  out_cost;
        logic [14:0] out_pred;
        logic        pred_valid;
        logic [15:0] out_label;
        logic        done_res;
    } t_res;

endpackage

FILE: rtl/core/ift_watershed_fmax.sv
// Top level of the seeded 3D watershed (fmax path cost, 6-neighborhood).
// Depends on wsf_pkg and wsf_ram.
//
// channel  | handshake               | payload
// command  | start, busy             | i_cmd  (wsf_pkg::t_cmd)
// result   | o_done_stb (one cycle)  | o_res  (wsf_pkg::t_res)
// config   | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// Load, seed and read pass through the voxel memory reads and, where needed, the
// queue link updates. Run does a predecessor sweep, then pops voxels and visits
// the neighbors of each with queue updates, passing over empty buckets, and then
// clears the colors and the bucket heads. After reset a clearing pass runs with
// busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module ift_watershed_fmax #(
    parameter int MAX_VOXELS = wsf_pkg::MAX_VOXELS_DEF,
    parameter int GRAD_BITS  = wsf_pkg::GRAD_BITS_DEF,
    parameter int LABEL_BITS = wsf_pkg::LABEL_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  wsf_pkg::t_cmd i_cmd,
    output logic          o_done_stb,
    output wsf_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [3:0]    i_cfg_data
);
    import wsf_pkg::*;

    localparam int AW    = $clog2(MAX_VOXELS);
    localparam int LIM   = $clog2(MAX_VOXELS + 1) - 1;
    localparam int GB    = GRAD_BITS;
    localparam int CB    = GRAD_BITS + 1;
    localparam int LW    = LABEL_BITS;
    localparam int NBD   = 1 << CB;
    localparam int VW    = GB + CB + LW;
    localparam int KW    = AW + 1;
    localparam int SWEEP = (MAX_VOXELS > NBD) ? MAX_VOXELS : NBD;
    localparam int IW    = $clog2(SWEEP + 1);
    localparam logic [CB-1:0] COST_INF = {CB{1'b1}};

    localparam logic [2:0] NB_ZM = 3'd0;
    localparam logic [2:0] NB_YM = 3'd1;
    localparam logic [2:0] NB_XM = 3'd2;
    localparam logic [2:0] NB_XP = 3'd3;
    localparam logic [2:0] NB_YP = 3'd4;
    localparam logic [2:0] NB_ZP = 3'd5;

    typedef enum logic [18:0] {
        S_CLR  = 19'h00001,
        S_IDLE = 19'h00002,
        S_FET  = 19'h00004,
        S_EXE  = 19'h00008,
        S_LDW  = 19'h00010,
        S_FIN  = 19'h00020,
        S_SWP  = 19'h00040,
        S_CHK  = 19'h00080,
        S_POP0 = 19'h00100,
        S_POP1 = 19'h00200,
        S_POP2 = 19'h00400,
        S_NB0  = 19'h00800,
        S_NB1  = 19'h01000,
        S_NXT  = 19'h02000,
        S_UNL0 = 19'h04000,
        S_UNL1 = 19'h08000,
        S_ENQ0 = 19'h10000,
        S_ENQ1 = 19'h20000,
        S_ENQ2 = 19'h40000
    } t_state;

    t_state r_state, n_state, r_ret_u, n_ret_u, r_ret_e, n_ret_e;
    t_cmd   r_cmd, n_cmd;
    t_res   r_res, n_res;
    logic   r_done, n_done;
    logic   r_inside, n_inside;
    logic [AW-1:0] r_q, n_q, r_p, n_p, r_t, n_t, r_swa, n_swa;
    logic [CB-1:0] r_b, n_b, r_c, n_c, r_min, n_min;
    logic [2:0]    r_k, n_k;
    logic [AW:0]   r_queued, n_queued;
    logic [IW-1:0] r_i, n_i;
    logic          r_swv, n_swv, r_clr_pred, n_clr_pred, r_clr_done, n_clr_done;
    logic [GB-1:0] r_pg, n_pg;
    logic [CB-1:0] r_pc, n_pc;
    logic [LW-1:0] r_pl, n_pl;
    logic [3:0]    r_cfg_x, r_cfg_y, r_cfg_z;

    logic          vox_we, prd_we, col_we, nxt_we, prv_we, hed_we, tal_we;
    logic [AW-1:0] vox_wa, prd_wa, col_wa, nxt_wa, prv_wa, vox_ra, prd_ra, col_ra;
    logic [AW-1:0] nxt_ra, prv_ra;
    logic [CB-1:0] hed_wa, tal_wa, hed_ra, tal_ra;
    logic [VW-1:0] vox_wd, vox_rd;
    logic [KW-1:0] prd_wd, prd_rd, nxt_wd, nxt_rd, prv_wd, prv_rd, hed_wd, hed_rd;
    logic [1:0]    col_wd, col_rd;
    logic [AW-1:0] tal_wd, tal_rd;

    logic [4:0]    w_lx, w_ly, w_lz, w_rem1, w_rem2, w_lxy, w_lsum;
    logic          w_inside;
    logic [AW-1:0] w_mx, w_my, w_mz, w_x, w_y, w_z, w_sy, w_sz, w_nq;
    logic          w_nok;
    logic [GB-1:0] w_vg;
    logic [CB-1:0] w_vc, w_edge, w_newc, w_vc_b;
    logic [LW-1:0] w_vl;

    assign busy        = (r_state != S_IDLE);
    assign o_done_stb  = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x <= 4'd5;
            r_cfg_y <= 4'd5;
            r_cfg_z <= 4'd5;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOG2_X: r_cfg_x <= i_cfg_data;
                CFG_LOG2_Y: r_cfg_y <= i_cfg_data;
                CFG_LOG2_Z: r_cfg_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // volume geometry, clipped to the memory size
    always_comb begin
        w_lx   = ({1'b0, r_cfg_x} > 5'(LIM)) ? 5'(LIM) : {1'b0, r_cfg_x};
        w_rem1 = 5'(LIM) - w_lx;
        w_ly   = ({1'b0, r_cfg_y} > w_rem1) ? w_rem1 : {1'b0, r_cfg_y};
        w_rem2 = w_rem1 - w_ly;
        w_lz   = ({1'b0, r_cfg_z} > w_rem2) ? w_rem2 : {1'b0, r_cfg_z};
        w_lxy  = w_lx + w_ly;
        w_lsum = w_lxy + w_lz;
        w_inside = ((i_cmd.address >> w_lsum) == 15'd0);
        w_mx = (AW'(1) << w_lx) - AW'(1);
        w_my = (AW'(1) << w_ly) - AW'(1);
        w_mz = (AW'(1) << w_lz) - AW'(1);
        w_sy = AW'(1) << w_lx;
        w_sz = AW'(1) << w_lxy;
        w_x  = r_p & w_mx;
        w_y  = (r_p >> w_lx) & w_my;
        w_z  = (r_p >> w_lxy) & w_mz;
        case (r_k)
            NB_ZM: begin w_nok = (w_z != '0);   w_nq = r_p - w_sz;     end
            NB_YM: begin w_nok = (w_y != '0);   w_nq = r_p - w_sy;     end
            NB_XM: begin w_nok = (w_x != '0);   w_nq = r_p - AW'(1);   end
            NB_XP: begin w_nok = (w_x != w_mx); w_nq = r_p + AW'(1);   end
            NB_YP: begin w_nok = (w_y != w_my); w_nq = r_p + w_sy;     end
            NB_ZP: begin w_nok = (w_z != w_mz); w_nq = r_p + w_sz;     end
            default: begin w_nok = 1'b0;        w_nq = r_p;            end
        endcase
        w_vg   = vox_rd[VW-1 -: GB];
        w_vc   = vox_rd[LW +: CB];
        w_vl   = vox_rd[LW-1:0];
        w_vc_b = (w_vc == COST_INF) ? COST_INF - CB'(1) : w_vc;
        w_edge = CB'(r_pg) + CB'(w_vg);
        w_newc = (r_pc > w_edge) ? r_pc : w_edge;
    end

    always_comb begin
        n_state = r_state;  n_ret_u = r_ret_u;  n_ret_e = r_ret_e;
        n_cmd = r_cmd;      n_res = r_res;      n_done = 1'b0;
        n_inside = r_inside; n_q = r_q;  n_p = r_p;  n_t = r_t;  n_swa = r_swa;
        n_b = r_b;  n_c = r_c;  n_min = r_min;  n_k = r_k;  n_queued = r_queued;
        n_i = r_i;  n_swv = r_swv;  n_clr_pred = r_clr_pred;  n_clr_done = r_clr_done;
        n_pg = r_pg;  n_pc = r_pc;  n_pl = r_pl;
        vox_we = 1'b0; vox_wa = r_q; vox_wd = vox_rd; vox_ra = r_q;
        prd_we = 1'b0; prd_wa = r_q; prd_wd = '0;     prd_ra = r_q;
        col_we = 1'b0; col_wa = r_q; col_wd = COL_WHITE; col_ra = r_q;
        nxt_we = 1'b0; nxt_wa = r_q; nxt_wd = '0;     nxt_ra = r_q;
        prv_we = 1'b0; prv_wa = r_q; prv_wd = '0;     prv_ra = r_q;
        hed_we = 1'b0; hed_wa = r_c; hed_wd = '0;     hed_ra = r_c;
        tal_we = 1'b0; tal_wa = r_c; tal_wd = r_q;    tal_ra = r_c;
        case (r_state)
            S_CLR: begin
                col_wa = r_i[AW-1:0];
                prd_wa = r_i[AW-1:0];
                hed_wa = r_i[CB-1:0];
                col_we = (r_i < IW'(MAX_VOXELS));
                prd_we = r_clr_pred && (r_i < IW'(MAX_VOXELS));
                hed_we = (r_i < IW'(NBD));
                n_i = r_i + IW'(1);
                if (r_i == IW'(SWEEP - 1)) begin
                    n_min = '0;
                    n_queued = '0;
                    n_state = r_clr_done ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    n_inside = w_inside;
                    n_q = AW'(i_cmd.address);
                    n_i = '0;
                    n_swv = 1'b0;
                    n_state = (i_cmd.cmd == CMD_RUN) ? S_SWP : S_FET;
                end
            end
            S_FET: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                case (r_cmd.cmd)
                    CMD_LOAD: begin
                        if (!r_inside) begin
                            n_state = S_FIN;
                        end else if (col_rd == COL_GRAY) begin
                            n_b = w_vc_b;
                            n_ret_u = S_LDW;
                            n_state = S_UNL0;
                        end else begin
                            n_state = S_LDW;
                        end
                    end
                    CMD_SEED: begin
                        if (!r_inside || col_rd == COL_GRAY) begin
                            n_state = S_FIN;
                        end else begin
                            vox_we = 1'b1;
                            vox_wd = {w_vg, {CB{1'b0}}, w_vl};
                            prd_we = 1'b1;
                            n_c = '0;
                            n_ret_e = S_FIN;
                            n_state = S_ENQ0;
                        end
                    end
                    default: begin
                        if (r_inside) begin
                            n_res.out_cost   = 9'(w_vc);
                            n_res.pred_valid = prd_rd[AW];
                            n_res.out_pred   = prd_rd[AW] ? 15'(prd_rd[AW-1:0]) : 15'd0;
                            n_res.out_label  = 16'(w_vl);
                        end else begin
                            n_res.out_cost = 9'(COST_INF);
                        end
                        n_state = S_FIN;
                    end
                endcase
            end
            S_LDW: begin
                vox_we = 1'b1;
                vox_wd = {GB'(r_cmd.gradient), CB'(r_cmd.init_cost), LW'(r_cmd.init_label)};
                col_we = 1'b1;
                col_wd = COL_WHITE;
                prd_we = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_done = 1'b1;
                n_res.done_res = 1'b1;
                n_state = S_IDLE;
            end
            S_SWP: begin
                col_ra = r_i[AW-1:0];
                prd_wa = r_swa;
                prd_we = r_swv && (col_rd != COL_GRAY);
                n_swa = r_i[AW-1:0];
                if (r_i == IW'(MAX_VOXELS)) begin
                    n_swv = 1'b0;
                    n_state = S_CHK;
                end else begin
                    n_swv = 1'b1;
                    n_i = r_i + IW'(1);
                end
            end
            S_CHK: begin
                if (r_queued == '0) begin
                    n_i = '0;
                    n_clr_pred = 1'b0;
                    n_clr_done = 1'b1;
                    n_state = S_CLR;
                end else begin
                    n_state = S_POP0;
                end
            end
            S_POP0: begin
                hed_ra = r_min;
                n_state = S_POP1;
            end
            S_POP1: begin
                if (!hed_rd[AW]) begin
                    n_min = r_min + CB'(1);
                    n_state = S_POP0;
                end else begin
                    n_p = hed_rd[AW-1:0];
                    nxt_ra = hed_rd[AW-1:0];
                    vox_ra = hed_rd[AW-1:0];
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                hed_we = 1'b1;
                hed_wa = r_min;
                hed_wd = nxt_rd;
                prv_we = nxt_rd[AW];
                prv_wa = nxt_rd[AW-1:0];
                col_we = 1'b1;
                col_wa = r_p;
                col_wd = COL_BLACK;
                n_queued = r_queued - KW'(1);
                n_pg = w_vg;
                n_pc = w_vc;
                n_pl = w_vl;
                n_k = NB_ZM;
                n_state = S_NB0;
            end
            S_NB0: begin
                col_ra = w_nq;
                vox_ra = w_nq;
                n_q = w_nq;
                n_state = w_nok ? S_NB1 : S_NXT;
            end
            S_NB1: begin
                if (col_rd != COL_BLACK && w_newc < w_vc) begin
                    vox_we = 1'b1;
                    vox_wd = {w_vg, w_newc, r_pl};
                    prd_we = 1'b1;
                    prd_wd = {1'b1, r_p};
                    n_b = w_vc_b;
                    n_c = w_newc;
                    n_ret_e = S_NXT;
                    n_ret_u = S_ENQ0;
                    n_state = (col_rd == COL_GRAY) ? S_UNL0 : S_ENQ0;
                end else begin
                    n_state = S_NXT;
                end
            end
            S_NXT: begin
                n_k = r_k + 3'd1;
                n_state = (r_k == NB_ZP) ? S_CHK : S_NB0;
            end
            S_UNL0: begin
                n_state = S_UNL1;
            end
            S_UNL1: begin
                if (prv_rd[AW]) begin
                    nxt_we = 1'b1;
                    nxt_wa = prv_rd[AW-1:0];
                    nxt_wd = nxt_rd;
                end else begin
                    hed_we = 1'b1;
                    hed_wa = r_b;
                    hed_wd = nxt_rd;
                end
                if (nxt_rd[AW]) begin
                    prv_we = 1'b1;
                    prv_wa = nxt_rd[AW-1:0];
                    prv_wd = prv_rd;
                end else if (prv_rd[AW]) begin
                    tal_we = 1'b1;
                    tal_wa = r_b;
                    tal_wd = prv_rd[AW-1:0];
                end
                col_we = 1'b1;
                col_wd = COL_BLACK;
                if (r_queued != '0) begin
                    n_queued = r_queued - KW'(1);
                end
                n_state = r_ret_u;
            end
            S_ENQ0: begin
                n_state = S_ENQ1;
            end
            S_ENQ1: begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
                prv_wd = hed_rd[AW] ? {1'b1, tal_rd} : '0;
                hed_we = !hed_rd[AW];
                hed_wd = {1'b1, r_q};
                tal_we = 1'b1;
                col_we = 1'b1;
                col_wd = COL_GRAY;
                if (r_c < r_min) begin
                    n_min = r_c;
                end
                n_queued = r_queued + KW'(1);
                n_t = tal_rd;
                n_state = hed_rd[AW] ? S_ENQ2 : r_ret_e;
            end
            S_ENQ2: begin
                nxt_we = 1'b1;
                nxt_wa = r_t;
                nxt_wd = {1'b1, r_q};
                n_state = r_ret_e;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ret_u    <= S_IDLE;
            r_ret_e    <= S_IDLE;
            r_done     <= 1'b0;
            r_i        <= '0;
            r_swv      <= 1'b0;
            r_clr_pred <= 1'b1;
            r_clr_done <= 1'b0;
            r_min      <= '0;
            r_queued   <= '0;
        end else begin
            r_state    <= n_state;
            r_ret_u    <= n_ret_u;
            r_ret_e    <= n_ret_e;
            r_done     <= n_done;
            r_i        <= n_i;
            r_swv      <= n_swv;
            r_clr_pred <= n_clr_pred;
            r_clr_done <= n_clr_done;
            r_min      <= n_min;
            r_queued   <= n_queued;
        end
        r_cmd    <= n_cmd;
        r_res    <= n_res;
        r_inside <= n_inside;
        r_q      <= n_q;
        r_p      <= n_p;
        r_t      <= n_t;
        r_swa    <= n_swa;
        r_b      <= n_b;
        r_c      <= n_c;
        r_k      <= n_k;
        r_pg     <= n_pg;
        r_pc     <= n_pc;
        r_pl     <= n_pl;
    end

    wsf_ram #(.WIDTH(VW), .DEPTH(MAX_VOXELS)) u_vox (
        .i_clk(i_clk), .i_we(vox_we), .i_waddr(vox_wa), .i_wdata(vox_wd),
        .i_raddr(vox_ra), .o_rdata(vox_rd));
    wsf_ram #(.WIDTH(KW), .DEPTH(MAX_VOXELS)) u_prd (
        .i_clk(i_clk), .i_we(prd_we), .i_waddr(prd_wa), .i_wdata(prd_wd),
        .i_raddr(prd_ra), .o_rdata(prd_rd));
    wsf_ram #(.WIDTH(2), .DEPTH(MAX_VOXELS)) u_col (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_wa), .i_wdata(col_wd),
        .i_raddr(col_ra), .o_rdata(col_rd));
    wsf_ram #(.WIDTH(KW), .DEPTH(MAX_VOXELS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_rd));
    wsf_ram #(.WIDTH(KW), .DEPTH(MAX_VOXELS)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_rd));
    wsf_ram #(.WIDTH(KW), .DEPTH(NBD)) u_hed (
        .i_clk(i_clk), .i_we(hed_we), .i_waddr(hed_wa), .i_wdata(hed_wd),
        .i_raddr(hed_ra), .o_rdata(hed_rd));
    wsf_ram #(.WIDTH(AW), .DEPTH(NBD)) u_tal (
        .i_clk(i_clk), .i_we(tal_we), .i_waddr(tal_wa), .i_wdata(tal_wd),
        .i_raddr(tal_ra), .o_rdata(tal_rd));
endmodule

FILE: rtl/core/wsf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module wsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/wsf_chk.sv
// Port-level checker of the watershed top level, bound to every instance.
// Depends on wsf_pkg and ift_watershed_fmax_defines.svh.
`timescale 1ns / 1ps
`include "ift_watershed_fmax_defines.svh"
module wsf_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done_stb,
    input wsf_pkg::t_res o_res
);
    `WSF_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `WSF_ASSERT_IMP(a_done_flag, o_done_stb, o_res.done_res)
    `WSF_ASSERT_IMP(a_done_idle, o_done_stb, !busy)
    `WSF_ASSERT_NXT(a_done_single, o_done_stb, !o_done_stb)
endmodule

bind ift_watershed_fmax wsf_chk u_wsf_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done_stb(o_done_stb), .o_res(o_res));
